@@ rtl/core/tcpoit_pkg.sv @@
// Package for the TCP out-of-order interval tracker.
// Holds command and outcome codes and the configuration register indexes.
// No dependencies.
package tcpoit_pkg;

  typedef enum logic [1:0] {
    CMD_PROCESS  = 2'd0,
    CMD_ESTIMATE = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_RSVD     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_SYN      = 3'd0,
    OUT_INORDER  = 3'd1,
    OUT_BEYOND   = 3'd2,
    OUT_DUP      = 3'd3,
    OUT_OOO      = 3'd4,
    OUT_FULL     = 3'd5,
    OUT_CLEARED  = 3'd6
  } outcome_t;

  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_COST_BASE = 2'd1;
  localparam logic [1:0] REG_COST_STEP = 2'd2;

  localparam logic [21:0] COST_MAX = 22'h3FFFFF;

endpackage

@@ rtl/core/tcpoit_in_if.sv @@
// Input channel interface of the interval tracker.
// Depends on nothing beyond the package widths.
interface tcpoit_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        syn;
  logic [31:0] seq_start;
  logic [31:0] seq_end;
  modport source (output valid, cmd, syn, seq_start, seq_end, input ready);
  modport sink (input valid, cmd, syn, seq_start, seq_end, output ready);
endinterface

@@ rtl/core/tcpoit_out_if.sv @@
// Result channel interface of the interval tracker.
// Depends on nothing beyond the package widths.
interface tcpoit_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic        cost_valid;
  logic [21:0] service_cost;
  logic [31:0] expected_seq;
  logic [4:0]  held_count;
  modport source (output valid, outcome, cost_valid, service_cost, expected_seq, held_count,
                  input ready);
  modport sink (input valid, outcome, cost_valid, service_cost, expected_seq, held_count,
                output ready);
endinterface

@@ rtl/core/tcp_ooo_interval_tracker_core.sv @@
// Top level of the TCP out-of-order interval tracker.
// Depends on tcpoit_pkg, tcpoit_in_if, tcpoit_out_if and tcpoit_cost.
//
// Use: items enter on the in channel (cmd, syn, seq_start, seq_end) with a
// valid/ready handshake. Every item gives exactly one result on the out
// channel (outcome, cost_valid, service_cost, expected_seq, held_count).
// The held intervals live in one synchronous memory of start/end pairs with
// a registered read. The sequencer handles one item at a time, and every
// memory entry it visits takes a read state, then a use state. A clear or a
// segment that is not out of order goes from the class state straight to
// the output state; an estimate passes through the cost state first. An
// out-of-order segment walks the list forward, walks back over the entries
// it may swallow, moves the tail, inserts, releases contiguous entries and
// closes the gap. The sequencer returns to idle, and the next item is
// accepted only in the idle state.
// The result sits in an output register until taken. While the receiver
// stalls, one more item is accepted and processed, and its result waits in
// the sequencer with in_ready low until the register is free.
// A synchronous active-low reset restores the register defaults and clears
// the expected number, the count and the output; memory contents are not
// cleared since only entries below the count are read. Configuration must
// be written over the APB port while no item is in flight; not enforced.
module tcp_ooo_interval_tracker_core #(
  parameter int MAX_INTERVALS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tcpoit_in_if.sink   in_ch,
  tcpoit_out_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int TW = $clog2(2 * MAX_INTERVALS + 2);
  localparam logic [CW-1:0] MAXC = CW'(MAX_INTERVALS);

  typedef enum logic [4:0] {
    S_IDLE, S_CLASS, S_FRD, S_FCHK, S_BRD, S_BCHK, S_DECIDE, S_URD, S_UWR,
    S_DRD, S_DWR, S_INS, S_RRD, S_RCHK, S_CUT, S_COST, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] window_r;
  logic [15:0] cbase_r, cstep_r;
  logic [31:0] nexp_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]  cmd_r;
  logic        syn_r;
  logic [31:0] s_r, e_r, first_r, last_r;
  logic [CW-1:0] pos_r, lo_r, idx_r, sh_r;
  logic        ins_r;
  logic [TW-1:0] trav_r;
  logic [2:0]  outc_r;
  logic        ovalid_r;
  logic [2:0]  res_outc_r;
  logic        res_cv_r;
  logic [21:0] res_cost_r;
  logic [31:0] res_exp_r;
  logic [4:0]  res_held_r;

  logic [31:0] mem_s [MAX_INTERVALS];
  logic [31:0] mem_e [MAX_INTERVALS];
  logic [31:0] rd_s, rd_e;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wd_s, wd_e;
  logic [CW-1:0] rcnt;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_s[waddr] <= wd_s;
      mem_e[waddr] <= wd_e;
    end
    rd_s <= mem_s[raddr];
    rd_e <= mem_e[raddr];
  end

  logic [21:0] cost;
  tcpoit_cost #(.CW(TW)) u_cost (
    .clk(clk), .base(cbase_r), .per_step(cstep_r), .steps(trav_r), .cost(cost));

  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    case (cfg_paddr[3:2])
      tcpoit_pkg::REG_WINDOW:    cfg_prdata = window_r;
      tcpoit_pkg::REG_COST_BASE: cfg_prdata = {16'd0, cbase_r};
      tcpoit_pkg::REG_COST_STEP: cfg_prdata = {16'd0, cstep_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.outcome = res_outc_r;
  assign out_ch.cost_valid = res_cv_r;
  assign out_ch.service_cost = res_cost_r;
  assign out_ch.expected_seq = res_exp_r;
  assign out_ch.held_count = res_held_r;

  assign rcnt = pos_r - lo_r;

  logic [2:0] cls;
  logic [32:0] wsum;
  assign wsum = {1'b0, nexp_r} + {1'b0, window_r};
  always_comb begin
    if (syn_r || nexp_r == 32'd0) cls = tcpoit_pkg::OUT_SYN;
    else if (cnt_r == '0 && nexp_r >= s_r) cls = tcpoit_pkg::OUT_INORDER;
    else if ({1'b0, s_r} > wsum) cls = tcpoit_pkg::OUT_BEYOND;
    else if (nexp_r >= e_r) cls = tcpoit_pkg::OUT_DUP;
    else cls = tcpoit_pkg::OUT_OOO;
  end

  // Memory port control, decoded from state.
  always_comb begin
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wd_s = rd_s;
    wd_e = rd_e;
    raddr = idx_r[AW-1:0];
    case (state_r)
      S_UWR: begin
        we = 1'b1;
        waddr = AW'(idx_r + CW'(1));
      end
      S_DWR: begin
        we = 1'b1;
        waddr = AW'(idx_r - sh_r);
      end
      S_INS: begin
        we = 1'b1;
        waddr = lo_r[AW-1:0];
        wd_s = first_r;
        wd_e = last_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      window_r <= 32'd65535;
      cbase_r <= 16'd0;
      cstep_r <= 16'd1;
      nexp_r <= 32'd0;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          tcpoit_pkg::REG_WINDOW:    window_r <= cfg_pwdata;
          tcpoit_pkg::REG_COST_BASE: cbase_r <= cfg_pwdata[15:0];
          tcpoit_pkg::REG_COST_STEP: cstep_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && (!ovalid_r || out_ch.ready)) begin
        ovalid_r <= 1'b1;
        res_outc_r <= outc_r;
        res_cv_r <= (outc_r == tcpoit_pkg::OUT_OOO);
        res_cost_r <= (outc_r == tcpoit_pkg::OUT_OOO) ? cost : 22'd0;
        res_exp_r <= nexp_r;
        res_held_r <= 5'(cnt_r);
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r <= in_ch.cmd;
            syn_r <= in_ch.syn;
            s_r <= in_ch.seq_start;
            e_r <= in_ch.seq_end;
            state_r <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (cmd_r == tcpoit_pkg::CMD_CLEAR) begin
            nexp_r <= 32'd0;
            cnt_r <= '0;
            outc_r <= tcpoit_pkg::OUT_CLEARED;
            state_r <= S_OUT;
          end else if (cmd_r != tcpoit_pkg::CMD_PROCESS) begin
            outc_r <= cls;
            trav_r <= TW'(cnt_r);
            state_r <= S_COST;
          end else begin
            outc_r <= cls;
            case (cls)
              tcpoit_pkg::OUT_SYN: begin
                if (cnt_r == '0) nexp_r <= e_r;
                state_r <= S_OUT;
              end
              tcpoit_pkg::OUT_INORDER: begin
                if (e_r > nexp_r) nexp_r <= e_r;
                state_r <= S_OUT;
              end
              tcpoit_pkg::OUT_OOO: begin
                pos_r <= '0;
                lo_r <= '0;
                idx_r <= '0;
                trav_r <= '0;
                first_r <= (s_r > nexp_r) ? s_r : nexp_r;
                last_r <= e_r;
                state_r <= (cnt_r == '0) ? S_DECIDE : S_FRD;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_FRD: state_r <= S_FCHK;
        S_FCHK: begin
          trav_r <= trav_r + TW'(1);
          if (e_r <= rd_e) begin
            if (rd_s < e_r) last_r <= rd_s;
            if (idx_r == '0) state_r <= S_DECIDE;
            else begin
              idx_r <= idx_r - CW'(1);
              state_r <= S_BRD;
            end
          end else if (idx_r + CW'(1) == cnt_r) begin
            pos_r <= cnt_r;
            state_r <= S_BRD;
          end else begin
            pos_r <= idx_r + CW'(1);
            idx_r <= idx_r + CW'(1);
            state_r <= S_FRD;
          end
        end
        S_BRD: state_r <= S_BCHK;
        S_BCHK: begin
          if (rd_s >= first_r) begin
            if (idx_r != '0) begin
              idx_r <= idx_r - CW'(1);
              state_r <= S_BRD;
            end else begin
              lo_r <= idx_r;
              state_r <= S_DECIDE;
            end
          end else begin
            lo_r <= idx_r + CW'(1);
            if (rd_e > first_r) first_r <= rd_e;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (last_r > first_r) begin
            if (cnt_r - rcnt >= MAXC) begin
              outc_r <= tcpoit_pkg::OUT_FULL;
              state_r <= S_OUT;
            end else if (rcnt == '0) begin
              if (pos_r == cnt_r) state_r <= S_INS;
              else begin
                idx_r <= cnt_r - CW'(1);
                state_r <= S_URD;
              end
            end else if (rcnt == CW'(1)) begin
              state_r <= S_INS;
            end else begin
              sh_r <= rcnt - CW'(1);
              ins_r <= 1'b1;
              idx_r <= pos_r;
              state_r <= (pos_r == cnt_r) ? S_INS : S_DRD;
            end
          end else if (rcnt == '0) begin
            state_r <= S_COST;
          end else begin
            sh_r <= rcnt;
            ins_r <= 1'b0;
            idx_r <= pos_r;
            state_r <= (pos_r == cnt_r) ? S_CUT : S_DRD;
          end
        end
        S_URD: state_r <= S_UWR;
        S_UWR: begin
          if (idx_r == pos_r) state_r <= S_INS;
          else begin
            idx_r <= idx_r - CW'(1);
            state_r <= S_URD;
          end
        end
        S_DRD: state_r <= S_DWR;
        S_DWR: begin
          if (idx_r + CW'(1) == cnt_r) state_r <= ins_r ? S_INS : S_CUT;
          else begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_DRD;
          end
        end
        S_INS: begin
          cnt_r <= cnt_r - rcnt + CW'(1);
          idx_r <= '0;
          state_r <= S_RRD;
        end
        S_RRD: state_r <= S_RCHK;
        S_RCHK: begin
          if (idx_r != cnt_r && nexp_r == rd_s) begin
            nexp_r <= rd_e;
            trav_r <= trav_r + TW'(1);
            idx_r <= idx_r + CW'(1);
            state_r <= S_RRD;
          end else if (idx_r == '0) begin
            state_r <= S_COST;
          end else begin
            sh_r <= idx_r;
            ins_r <= 1'b0;
            state_r <= (idx_r == cnt_r) ? S_CUT : S_DRD;
          end
        end
        S_CUT: begin
          cnt_r <= cnt_r - sh_r;
          state_r <= S_COST;
        end
        S_COST: state_r <= S_OUT;
        S_OUT: begin
          if (!ovalid_r || out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ap_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAXC)
    else $error("held count above capacity");
  ap_cv: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.cost_valid |-> out_ch.outcome == tcpoit_pkg::OUT_OOO)
    else $error("cost valid on wrong outcome");
  ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("accepted during work");
endmodule

@@ rtl/core/tcpoit_cost.sv @@
// Cost unit: saturating cost_base + cost_per_step * steps, one registered stage.
// Depends on tcpoit_pkg.
module tcpoit_cost #(
  parameter int CW = 9
) (
  input  logic          clk,
  input  logic [15:0]   base,
  input  logic [15:0]   per_step,
  input  logic [CW-1:0] steps,
  output logic [21:0]   cost
);
  logic [31:0] prod_r;
  logic [32:0] sum;

  always_ff @(posedge clk) begin
    prod_r <= 32'(per_step) * 32'(steps);
  end

  assign sum  = {1'b0, prod_r} + 33'(base);
  assign cost = (sum > 33'(tcpoit_pkg::COST_MAX)) ? tcpoit_pkg::COST_MAX : sum[21:0];
endmodule
